>>> hdl/rts_pkg.sv
// Shared types, constants and helpers for the RGBA8 tile swizzler.
// No dependencies; the front end, queue, back end, top level and testbench files import it.
package rts_pkg;

	localparam int TILE_DIM       = 4;
	localparam int PIX_W          = 32;
	localparam int ROW_W          = TILE_DIM * PIX_W;
	localparam int CFG_W          = 9;
	localparam int JOB_QDEPTH     = 2;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [1:0] LAST_ROW = 2'(TILE_DIM - 1);
	localparam logic [1:0] LAST_COL = 2'(TILE_DIM - 1);
	localparam logic [2:0] LAST_WORD = 3'(2 * TILE_DIM - 1);

	// register map, index = byte address / 4
	typedef enum logic [0:0] {
		REG_WIDTH_TILES  = 1'b0,
		REG_HEIGHT_TILES = 1'b1
	} reg_idx_t;

	// configuration seen by the front end
	typedef struct packed {
		logic [CFG_W-1:0] width_tiles;
		logic [CFG_W-1:0] height_tiles;
		logic             restart;
	} cfg_t;

	// one complete tile: four rows of four {r,g,b,a} pixels
	typedef struct packed {
		logic [TILE_DIM-1:0][ROW_W-1:0] rows;
		logic                           last_img;
	} job_t;

	// zero acts as one, anything above the limit acts as the limit
	function automatic int clamp_tiles(logic [CFG_W-1:0] v, int maxv);
		int r;
		r = int'(v);
		if (r == 0) begin
			r = 1;
		end else if (r > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

endpackage

>>> hdl/rts_pixel_if.sv
// Pixel request channel: valid/ready handshake with one RGBA pixel.
// Depends on nothing.
interface rts_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

>>> hdl/rts_word_if.sv
// Output word channel: valid/ready handshake with four pairs and tile flags.
// Depends on nothing.
interface rts_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] pair_zero;
	logic [15:0] pair_one;
	logic [15:0] pair_two;
	logic [15:0] pair_three;
	logic        plane;
	logic [1:0]  tile_row;
	logic        last_in_tile;
	logic        last_in_image;

	modport source (output valid, pair_zero, pair_one, pair_two, pair_three,
		plane, tile_row, last_in_tile, last_in_image, input ready);
	modport sink (input valid, pair_zero, pair_one, pair_two, pair_three,
		plane, tile_row, last_in_tile, last_in_image, output ready);
endinterface

>>> hdl/rts_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/rts_front.sv
// Front end: takes raster pixels, stores rows 0..2 of the band in RAM,
// gathers a full tile during row 3 and pushes it as a job. Uses rts_pkg, rts_ram.
module rts_front #(
	parameter int MAX_WIDTH  = rts_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rts_pkg::DEF_MAX_HEIGHT
) (
	input  logic          clk,
	input  logic          arst_n,
	rts_pixel_if.sink     pix,
	input  rts_pkg::cfg_t cfg,
	input  logic          q_full,
	output logic          push,
	output rts_pkg::job_t job
);
	import rts_pkg::*;

	localparam int TW    = MAX_WIDTH / TILE_DIM;
	localparam int TH    = MAX_HEIGHT / TILE_DIM;
	localparam int TCW   = (TW > 1) ? $clog2(TW) : 1;
	localparam int HBW   = (TH > 1) ? $clog2(TH) : 1;
	localparam int DEPTH = 3 * TW;
	localparam int AW    = $clog2(DEPTH);

	logic [1:0]       k_q;
	logic [1:0]       row_q;
	logic [TCW-1:0]   tcol_q;
	logic [HBW-1:0]   band_q;
	logic [TCW-1:0]   wlast;
	logic [HBW-1:0]   hlast;
	logic             acc;
	logic             row_end;
	logic             band_end;
	logic [PIX_W-1:0] px;
	logic [2:0][PIX_W-1:0] acc_q;
	logic [2:0][ROW_W-1:0] tile_q;
	logic             rd_pend_q;
	logic [1:0]       rd_row_q;
	logic             ram_we;
	logic             ram_re;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [ROW_W-1:0] wdata;
	logic [ROW_W-1:0] rdata;
	logic [ROW_W-1:0] row_two;

	// effective last tile column and last band
	assign wlast = TCW'(clamp_tiles(cfg.width_tiles, TW) - 1);
	assign hlast = HBW'(clamp_tiles(cfg.height_tiles, TH) - 1);

	assign pix.ready = !q_full;
	assign acc       = pix.valid && pix.ready;
	assign px        = {pix.red, pix.green, pix.blue, pix.alpha};
	assign row_end   = (tcol_q == wlast);
	assign band_end  = (band_q == hlast);

	// rows 0..2: write a tile row once its fourth pixel arrives
	assign ram_we = acc && (row_q != LAST_ROW) && (k_q == LAST_COL);
	assign waddr  = AW'(int'(row_q) * TW + int'(tcol_q));
	assign wdata  = {px, acc_q[2], acc_q[1], acc_q[0]};

	// row 3: fetch stored row k of the tile while pixel k comes in
	assign ram_re = acc && (row_q == LAST_ROW) && (k_q != LAST_COL);
	assign raddr  = AW'(int'(k_q) * TW + int'(tcol_q));

	rts_ram #(.WIDTH(ROW_W), .DEPTH(DEPTH)) u_band_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// row 2 may still sit in the RAM output register
	assign row_two = (rd_pend_q && rd_row_q == 2'd2) ? rdata : tile_q[2];

	// job push on the pixel that completes the tile
	assign push          = acc && (row_q == LAST_ROW) && (k_q == LAST_COL);
	assign job.rows      = {{px, acc_q[2], acc_q[1], acc_q[0]}, row_two, tile_q[1], tile_q[0]};
	assign job.last_img  = row_end && band_end;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			row_q     <= '0;
			tcol_q    <= '0;
			band_q    <= '0;
			rd_pend_q <= 1'b0;
		end else if (cfg.restart) begin
			k_q       <= '0;
			row_q     <= '0;
			tcol_q    <= '0;
			band_q    <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= ram_re;
			if (acc) begin
				if (k_q == LAST_COL) begin
					k_q <= '0;
					if (row_end) begin
						tcol_q <= '0;
						if (row_q == LAST_ROW) begin
							row_q  <= '0;
							band_q <= band_end ? '0 : band_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						tcol_q <= tcol_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	// pixel gather and stored-row capture
	always_ff @(posedge clk) begin
		if (acc) begin
			case (k_q)
				2'd0: acc_q[0] <= px;
				2'd1: acc_q[1] <= px;
				2'd2: acc_q[2] <= px;
				default: ;
			endcase
		end
		if (ram_re) begin
			rd_row_q <= k_q;
		end
		if (rd_pend_q) begin
			case (rd_row_q)
				2'd0: tile_q[0] <= rdata;
				2'd1: tile_q[1] <= rdata;
				2'd2: tile_q[2] <= rdata;
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("band RAM read and write in the same cycle");
	a_rd_row: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> (rd_row_q != LAST_ROW))
		else $error("fetch of a row that is never stored");
`endif

endmodule

>>> hdl/rts_job_fifo.sv
// Short queue of complete tiles between front and back end.
// Uses rts_pkg for the job type.
module rts_job_fifo #(
	parameter int DEPTH = rts_pkg::JOB_QDEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rts_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output rts_pkg::job_t pop_data,
	output logic          valid
);
	import rts_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t            mem_q [DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW:0]     cnt_q;

	assign full     = (cnt_q == (PW+1)'(DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("tile queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("tile queue underflow");
`endif

endmodule

>>> hdl/rts_back.sv
// Back end: takes one tile at a time and sends its eight words through an
// output register. Uses rts_pkg and rts_word_if.
module rts_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  rts_pkg::job_t q_data,
	output logic          pop,
	rts_word_if.source    word
);
	import rts_pkg::*;

	job_t        tile_q;
	logic        busy_q;
	logic [2:0]  cnt_q;
	logic        ov_q;
	logic        load_word;
	logic        plane;
	logic [1:0]  trow;
	logic [ROW_W-1:0] row_px;
	logic [TILE_DIM-1:0][15:0] pairs;
	logic [TILE_DIM-1:0][15:0] pairs_q;
	logic        plane_q;
	logic [1:0]  trow_q;
	logic        lt_q;
	logic        li_q;

	assign load_word = busy_q && (!ov_q || word.ready);
	assign pop       = q_valid && (!busy_q || (load_word && cnt_q == LAST_WORD));
	assign plane     = cnt_q[2];
	assign trow      = cnt_q[1:0];
	assign row_px    = tile_q.rows[trow];

	// pixel {r,g,b,a} -> {a,r} or {g,b}
	always_comb begin
		for (int k = 0; k < TILE_DIM; k++) begin
			if (plane) begin
				pairs[k] = row_px[k*PIX_W+8 +: 16];
			end else begin
				pairs[k] = {row_px[k*PIX_W +: 8], row_px[k*PIX_W+24 +: 8]};
			end
		end
	end

	// tile sequencing and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load_word) begin
				ov_q <= 1'b1;
			end else if (word.ready) begin
				ov_q <= 1'b0;
			end
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (load_word) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_WORD) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// tile and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			tile_q <= q_data;
		end
		if (load_word) begin
			pairs_q <= pairs;
			plane_q <= plane;
			trow_q  <= trow;
			lt_q    <= (cnt_q == LAST_WORD);
			li_q    <= (cnt_q == LAST_WORD) && tile_q.last_img;
		end
	end

	assign word.valid         = ov_q;
	assign word.pair_zero     = pairs_q[0];
	assign word.pair_one      = pairs_q[1];
	assign word.pair_two      = pairs_q[2];
	assign word.pair_three    = pairs_q[3];
	assign word.plane         = plane_q;
	assign word.tile_row      = trow_q;
	assign word.last_in_tile  = lt_q;
	assign word.last_in_image = li_q;

`ifndef NO_ASSERTIONS
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && lt_q) |-> (plane_q && trow_q == LAST_ROW))
		else $error("tile end flag on a word other than the eighth");
`endif

endmodule

>>> hdl/rgba8_tile_swizzler.sv
// Throughput: 1 pixel/cycle while the tile queue is not full; intake stalls whenever
// the 2-tile queue fills, since the output port sends 8 words per tile.
// Reset: counters, queue and registers (width/height = 1) clear asynchronously;
// band RAM contents are left as they are and need no clearing pass.
// Uses rts_pkg, rts_pixel_if, rts_word_if, rts_front, rts_job_fifo, rts_back.
module rgba8_tile_swizzler #(
	parameter int MAX_WIDTH  = rts_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = rts_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	rts_pixel_if.sink   pix,
	rts_word_if.source  word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rts_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             wr;
	reg_idx_t         idx;
	cfg_t             cfg;
	logic             push;
	job_t             push_job;
	logic             q_full;
	logic             q_valid;
	logic             pop;
	job_t             q_data;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (wr) begin
			case (idx)
				REG_WIDTH_TILES:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT_TILES: height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (idx)
			REG_WIDTH_TILES:  prdata = 32'(width_q);
			REG_HEIGHT_TILES: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.width_tiles  = width_q;
	assign cfg.height_tiles = height_q;
	assign cfg.restart      = wr;

	rts_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.pix   (pix),
		.cfg   (cfg),
		.q_full(q_full),
		.push  (push),
		.job   (push_job)
	);

	rts_job_fifo #(.DEPTH(JOB_QDEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_data (q_data),
		.valid    (q_valid)
	);

	rts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_data (q_data),
		.pop    (pop),
		.word   (word)
	);

endmodule

>>> test/tile_check_pkg.sv
// Expected-word tracker for the RGBA8 tile swizzler testbench: a software copy
// of the band buffer that predicts each tiled output word and checks the DUT.
// Depends on rts_pkg for the tile size, the register indexes and the size limits.
package tile_check_pkg;
	import rts_pkg::*;

	localparam int unsigned STORE_COLS = DEF_MAX_WIDTH;
	localparam int unsigned TOP_TILES_W = DEF_MAX_WIDTH / TILE_DIM;
	localparam int unsigned TOP_TILES_H = DEF_MAX_HEIGHT / TILE_DIM;

	typedef struct packed {
		logic [15:0] pair_zero;
		logic [15:0] pair_one;
		logic [15:0] pair_two;
		logic [15:0] pair_three;
		logic        plane;
		logic [1:0]  tile_row;
		logic        last_in_tile;
		logic        last_in_image;
	} tile_word_t;

	class tile_word_checker;
		// rows 0..2 of the band, plus row 3 of the tile in progress
		logic [31:0]     band_rows [3 * STORE_COLS];
		logic [31:0]     row3_px [TILE_DIM];
		int unsigned     col_pos;
		int unsigned     row_in_band;
		int unsigned     band_num;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		tile_word_t      tile_words_due [$];
		int unsigned     pixels_taken;
		int unsigned     words_checked;
		int unsigned     failures;

		function new();
			width_reg = 1;
			height_reg = 1;
			col_pos = 0;
			row_in_band = 0;
			band_num = 0;
			pixels_taken = 0;
			words_checked = 0;
			failures = 0;
		endfunction

		// zero acts as one, values over the limit act as the limit
		static function int unsigned fit_tiles(logic [CFG_W-1:0] v, int unsigned top);
			if (v == 0) begin
				return 1;
			end
			if (int'(v) > top) begin
				return top;
			end
			return int'(v);
		endfunction

		function int unsigned image_pixels();
			return fit_tiles(width_reg, TOP_TILES_W) * fit_tiles(height_reg, TOP_TILES_H)
				* TILE_DIM * TILE_DIM;
		endfunction

		function int unsigned words_due();
			return tile_words_due.size();
		endfunction

		// any register write restarts the image at band 0, pixel 0
		function void write_register(reg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_WIDTH_TILES: begin
					width_reg = v;
				end
				REG_HEIGHT_TILES: begin
					height_reg = v;
				end
				default: ;
			endcase
			col_pos = 0;
			row_in_band = 0;
			band_num = 0;
		endfunction

		// buffer one accepted pixel; the last pixel of a tile queues its 8 words
		function void take_pixel(logic [31:0] px);
			int unsigned     width_px;
			int unsigned     bands;
			int unsigned     base;
			bit              row_end;
			bit              band_end;
			logic [31:0]     src;
			logic [3:0][15:0] pairs;
			tile_word_t      w;

			width_px = fit_tiles(width_reg, TOP_TILES_W) * TILE_DIM;
			bands = fit_tiles(height_reg, TOP_TILES_H);
			row_end = (col_pos + 1 >= width_px);
			band_end = (band_num + 1 >= bands);
			pixels_taken++;

			if (row_in_band < LAST_ROW) begin
				band_rows[row_in_band * STORE_COLS + col_pos] = px;
			end else begin
				row3_px[col_pos % TILE_DIM] = px;
				if (col_pos % TILE_DIM == LAST_COL) begin
					base = col_pos - LAST_COL;
					for (int pl = 0; pl < 2; pl++) begin
						for (int r = 0; r < TILE_DIM; r++) begin
							for (int k = 0; k < TILE_DIM; k++) begin
								src = (r == LAST_ROW) ? row3_px[k]
									: band_rows[r * STORE_COLS + base + k];
								// plane 0: alpha|red, plane 1: green|blue
								pairs[k] = (pl == 0) ? {src[7:0], src[31:24]}
									: {src[23:16], src[15:8]};
							end
							w.pair_zero = pairs[0];
							w.pair_one = pairs[1];
							w.pair_two = pairs[2];
							w.pair_three = pairs[3];
							w.plane = pl[0];
							w.tile_row = r[1:0];
							w.last_in_tile = (pl == 1) && (r == LAST_ROW);
							w.last_in_image = w.last_in_tile && row_end && band_end;
							tile_words_due.push_back(w);
						end
					end
				end
			end

			// advance the raster position, wrapping at the end of the image
			if (row_end) begin
				col_pos = 0;
				if (row_in_band >= LAST_ROW) begin
					row_in_band = 0;
					band_num = band_end ? 0 : band_num + 1;
				end else begin
					row_in_band++;
				end
			end else begin
				col_pos++;
			end
		endfunction

		function bit field_differs(string name, int unsigned want, int unsigned got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void check_word(tile_word_t got);
			tile_word_t want;
			bit         bad;

			if (tile_words_due.size() == 0) begin
				$error("output word 0x%0h with none expected", got);
				failures++;
				return;
			end
			want = tile_words_due.pop_front();
			words_checked++;
			bad = 0;
			bad |= field_differs("pair_zero", want.pair_zero, got.pair_zero);
			bad |= field_differs("pair_one", want.pair_one, got.pair_one);
			bad |= field_differs("pair_two", want.pair_two, got.pair_two);
			bad |= field_differs("pair_three", want.pair_three, got.pair_three);
			bad |= field_differs("plane", want.plane, got.plane);
			bad |= field_differs("tile_row", want.tile_row, got.tile_row);
			bad |= field_differs("last_in_tile", want.last_in_tile, got.last_in_tile);
			bad |= field_differs("last_in_image", want.last_in_image, got.last_in_image);
			if (bad) begin
				failures++;
			end
		endfunction
	endclass

endpackage

>>> test/testbench.sv
// Top-level testbench for rgba8_tile_swizzler: streams raster pixels under several
// image sizes and idle patterns and checks every tiled word against a prediction.
// Depends on rts_pkg, rts_pixel_if, rts_word_if, tile_check_pkg and the DUT.
module testbench;
	import rts_pkg::*;
	import tile_check_pkg::*;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	localparam int QUIET_LIMIT   = 5000;
	localparam int RANDOM_PIXELS = 360;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int          quiet_cycles = 0;
	int unsigned phase_count = 0;

	tile_word_checker sb;

	rts_pixel_if pix_if();
	rts_word_if  word_if();

	rgba8_tile_swizzler DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_if),
		.word    (word_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// output side: check each accepted word, then pick the next ready
	always @(posedge clk) begin
		if (word_if.valid && word_if.ready) begin
			sb.check_word('{word_if.pair_zero, word_if.pair_one, word_if.pair_two,
				word_if.pair_three, word_if.plane, word_if.tile_row,
				word_if.last_in_tile, word_if.last_in_image});
		end
		word_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// cycles with no request moving on either side
	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (word_if.valid && word_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
		$display("rgba8_tile_swizzler: mismatch");
		$finish;
	end

	task automatic set_idle(idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SEND) ? 84 : (mode == IDLE_BOTH) ? 23 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 84 : (mode == IDLE_BOTH) ? 23 : 0;
	endtask

	// setup then access write, then psel drops so back-to-back writes never collide
	task automatic reg_write(reg_idx_t idx, logic [CFG_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {(32 - CFG_W)'($urandom_range(0, (1 << (32 - CFG_W)) - 1)), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		sb.write_register(idx, v);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// optional gap, then hold the pixel until it is taken
	task automatic send_pixel(logic [31:0] px);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.red <= px[31:24];
		pix_if.green <= px[23:16];
		pix_if.blue <= px[15:8];
		pix_if.alpha <= px[7:0];
		@(posedge clk);
		while (!pix_if.ready) begin
			@(posedge clk);
		end
		sb.take_pixel(px);
	endtask

	task automatic stop_pixels();
		pix_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain_words();
		while (sb.words_due() != 0) begin
			@(posedge clk);
		end
	endtask

	// random pixels, optionally holding off halfway until the output is empty
	task automatic run_pixels(int unsigned count, bit hold_midway);
		for (int unsigned i = 0; i < count; i++) begin
			if (hold_midway && i == count / 2) begin
				stop_pixels();
				drain_words();
			end
			send_pixel($urandom());
		end
		stop_pixels();
		drain_words();
		repeat (SETTLE_CYCLES) @(posedge clk);
		phase_count++;
	endtask

	initial begin
		int unsigned      random_sent;
		int unsigned      count;
		int unsigned      img;
		logic [CFG_W-1:0] wv;
		logic [CFG_W-1:0] hv;
		logic [7:0]       bit_hot;

		sb = new();
		pix_if.valid <= 1'b0;
		pix_if.red <= '0;
		pix_if.green <= '0;
		pix_if.blue <= '0;
		pix_if.alpha <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size (one tile): all-zero, all-one, then walking-bit pixels
		set_idle(IDLE_NONE);
		for (int i = 0; i < 16; i++) begin
			bit_hot = 8'(1 << (i % 8));
			case (i)
				0: send_pixel(32'h0000_0000);
				1: send_pixel(32'hFFFF_FFFF);
				default: send_pixel({8'(i * 16 + 1), 8'(255 - i * 16), bit_hot, ~bit_hot});
			endcase
		end
		// start a second image, then rewrite the same width: must restart
		for (int i = 0; i < 4; i++) begin
			send_pixel($urandom());
		end
		stop_pixels();
		drain_words();
		repeat (SETTLE_CYCLES) @(posedge clk);
		reg_write(REG_WIDTH_TILES, CFG_W'(1));

		// random small images, whole ones mostly, some cut short; every idle mode
		random_sent = 0;
		while (random_sent < RANDOM_PIXELS || phase_count < 4) begin
			set_idle(idle_mode_t'(phase_count % 4));
			wv = ($urandom_range(0, 9) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 3));
			hv = ($urandom_range(0, 9) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 2));
			reg_write(REG_WIDTH_TILES, wv);
			if ($urandom_range(0, 3) != 0) begin
				reg_write(REG_HEIGHT_TILES, hv);
			end
			img = sb.image_pixels();
			count = img * $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0) begin
				count += $urandom_range(1, img - 1);
			end
			run_pixels(count, phase_count == 2);
			random_sent += count;
		end

		// start of the widest image: over-range width clamps, zero height acts
		// as one band; only band row 0 is sent, so no word is due
		set_idle(IDLE_NONE);
		reg_write(REG_WIDTH_TILES, 9'h1FF);
		reg_write(REG_HEIGHT_TILES, CFG_W'(0));
		run_pixels(32, 1'b0);

		// first bands of the tallest image at one tile wide
		set_idle(IDLE_BOTH);
		reg_write(REG_WIDTH_TILES, CFG_W'(1));
		reg_write(REG_HEIGHT_TILES, CFG_W'(256));
		run_pixels(48, 1'b0);

		stop_pixels();
		drain_words();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d pixels in %0d phases, %0d tiled words checked",
			sb.pixels_taken, phase_count, sb.words_checked);
		$display("small images plus the start of the widest and tallest, %0d failures",
			sb.failures);
		if (sb.failures == 0 && sb.words_due() == 0) begin
			$display("rgba8_tile_swizzler: match");
		end else begin
			$display("rgba8_tile_swizzler: mismatch");
		end
		$finish;
	end

endmodule
